// ----- rtl/dalu_pkg.sv -----
package dalu_pkg;

   // two-operand opcodes, codes fourteen and fifteen are unassigned
   typedef enum logic [3:0] {
      OP_BIT  = 4'd0,
      OP_BITB = 4'd1,
      OP_BIC  = 4'd2,
      OP_BICB = 4'd3,
      OP_BIS  = 4'd4,
      OP_BISB = 4'd5,
      OP_ADD  = 4'd6,
      OP_SUB  = 4'd7,
      OP_MOV  = 4'd8,
      OP_MOVB = 4'd9,
      OP_CMP  = 4'd10,
      OP_CMPB = 4'd11,
      OP_XOR  = 4'd12,
      OP_MUL  = 4'd13
   } opcode_type;

   localparam int WORD_WIDTH = 16;
   localparam int BYTE_WIDTH = 8;

   typedef struct packed {
      logic [3:0]            opcode;
      logic [WORD_WIDTH-1:0] src_value;
      logic [WORD_WIDTH-1:0] dst_value;
   } req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] result_word;
      logic [WORD_WIDTH-1:0] product_high;
      logic                  write_back;
      logic                  flag_n;
      logic                  flag_z;
      logic                  flag_v;
      logic                  flag_c;
      logic                  c_update;
   } rsp_type;

endpackage

// ----- rtl/double_operand_alu.sv -----
// two-operand execute unit: logical ops, add, sub, cmp, mov, xor, signed multiply
// a beat taken into the input register is computed, held in the result register, and shown on rsp_strobe/rsp_item
// throughput: one beat per cycle, set by the input register and the result register
// busy is held low; the receiver cannot stall, every result is shown for one cycle only
// reset (synchronous, active high) clears both valid stages; payload registers are not reset
module double_operand_alu (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dalu_pkg::req_type req_item,
   output logic              rsp_strobe,
   output dalu_pkg::rsp_type rsp_item
);
   import dalu_pkg::*;

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;

   // result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff, rsp_item_in;

   // no internal stall: a beat can enter every cycle
   assign busy        = 1'b0;
   assign in_valid_in = start & ~busy;

   // operands of the registered beat
   logic [WORD_WIDTH-1:0] s, d;
   logic [BYTE_WIDTH-1:0] sb, db;
   assign s  = in_item_ff.src_value;
   assign d  = in_item_ff.dst_value;
   assign sb = s[BYTE_WIDTH-1:0];
   assign db = d[BYTE_WIDTH-1:0];

   // arithmetic, carry and borrow come out of the extra top bit
   logic [WORD_WIDTH:0] add_full, sub_full, cmp_full;
   logic [BYTE_WIDTH:0] cmpb_full;
   assign add_full  = {1'b0, s} + {1'b0, d};
   assign sub_full  = {1'b0, d} - {1'b0, s};
   assign cmp_full  = {1'b0, s} - {1'b0, d};
   assign cmpb_full = {1'b0, sb} - {1'b0, db};

   // signed overflow, sign bits of the operands against the sign of the result
   logic add_v, sub_v, cmp_v, cmpb_v;
   assign add_v  = ~(s[WORD_WIDTH-1] ^ d[WORD_WIDTH-1])
                 & (s[WORD_WIDTH-1] ^ add_full[WORD_WIDTH-1]);
   assign sub_v  = (s[WORD_WIDTH-1] ^ d[WORD_WIDTH-1])
                 & ~(s[WORD_WIDTH-1] ^ sub_full[WORD_WIDTH-1]);
   assign cmp_v  = (s[WORD_WIDTH-1] ^ d[WORD_WIDTH-1])
                 & ~(d[WORD_WIDTH-1] ^ cmp_full[WORD_WIDTH-1]);
   assign cmpb_v = (sb[BYTE_WIDTH-1] ^ db[BYTE_WIDTH-1])
                 & ~(db[BYTE_WIDTH-1] ^ cmpb_full[BYTE_WIDTH-1]);

   // 16x16 signed multiply, one multiplier in this stage
   logic signed [2*WORD_WIDTH-1:0] product;
   logic                           mul_out_of_range;
   assign product = $signed(s) * $signed(d);
   // fits in 16-bit signed only when the top seventeen bits all agree
   assign mul_out_of_range = ~((&product[2*WORD_WIDTH-1:WORD_WIDTH-1])
                             | ~(|product[2*WORD_WIDTH-1:WORD_WIDTH-1]));

   always_comb begin
      logic [WORD_WIDTH-1:0] res;
      logic                  byte_op;
      logic                  known;
      res         = '0;
      byte_op     = 1'b0;
      known       = 1'b1;
      rsp_item_in = '0;
      rsp_item_in.write_back = 1'b1;
      unique case (in_item_ff.opcode)
         OP_BIT: begin
            res = s & d;
            rsp_item_in.write_back = 1'b0;
         end
         OP_BITB: begin
            res = s & d;
            byte_op = 1'b1;
            rsp_item_in.write_back = 1'b0;
         end
         OP_BIC:  res = ~s & d;
         OP_BICB: begin
            res = ~s & d;
            byte_op = 1'b1;
         end
         OP_BIS:  res = s | d;
         OP_BISB: begin
            res = s | d;
            byte_op = 1'b1;
         end
         OP_ADD: begin
            res = add_full[WORD_WIDTH-1:0];
            rsp_item_in.flag_v   = add_v;
            rsp_item_in.flag_c   = add_full[WORD_WIDTH];
            rsp_item_in.c_update = 1'b1;
         end
         OP_SUB: begin
            res = sub_full[WORD_WIDTH-1:0];
            rsp_item_in.flag_v   = sub_v;
            rsp_item_in.flag_c   = sub_full[WORD_WIDTH];
            rsp_item_in.c_update = 1'b1;
         end
         OP_MOV:  res = s;
         OP_MOVB: begin
            res = s;
            byte_op = 1'b1;
         end
         OP_CMP: begin
            res = cmp_full[WORD_WIDTH-1:0];
            rsp_item_in.flag_v     = cmp_v;
            rsp_item_in.flag_c     = cmp_full[WORD_WIDTH];
            rsp_item_in.c_update   = 1'b1;
            rsp_item_in.write_back = 1'b0;
         end
         OP_CMPB: begin
            res = {{(WORD_WIDTH-BYTE_WIDTH){1'b0}}, cmpb_full[BYTE_WIDTH-1:0]};
            byte_op = 1'b1;
            rsp_item_in.flag_v     = cmpb_v;
            rsp_item_in.flag_c     = cmpb_full[BYTE_WIDTH];
            rsp_item_in.c_update   = 1'b1;
            rsp_item_in.write_back = 1'b0;
         end
         OP_XOR:  res = s ^ d;
         OP_MUL:  res = product[WORD_WIDTH-1:0];
         default: known = 1'b0;
      endcase

      if (byte_op) begin
         res[WORD_WIDTH-1:BYTE_WIDTH] = '0;
      end
      rsp_item_in.result_word = res;
      rsp_item_in.flag_n = byte_op ? res[BYTE_WIDTH-1] : res[WORD_WIDTH-1];
      rsp_item_in.flag_z = ~(|res);

      // multiply flags come from the full 32-bit product
      if (in_item_ff.opcode == OP_MUL) begin
         rsp_item_in.product_high = product[2*WORD_WIDTH-1:WORD_WIDTH];
         rsp_item_in.flag_n       = product[2*WORD_WIDTH-1];
         rsp_item_in.flag_z       = ~(|product);
         rsp_item_in.flag_c       = mul_out_of_range;
         rsp_item_in.c_update     = 1'b1;
      end

      // unassigned opcodes give an all-zero result
      if (!known) begin
         rsp_item_in = '0;
      end
   end

   assign rsp_valid_in = in_valid_ff;

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload pipeline, loaded only with a live beat
   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_item_ff <= req_item;
      end
      if (rsp_valid_in) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

`ifndef NO_ASSERTIONS
   // every accepted beat comes out on rsp_strobe after passing the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted beat did not produce a result");

   // no result without a beat held in the input register before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(in_valid_ff))
      else $error("result strobe without an accepted beat");

   // carry flag is only meaningful with its update mark
   a_carry_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.c_update) |-> !rsp_item.flag_c)
      else $error("flag_c set without c_update");

   // a nonzero upper product only comes from multiply
   a_product_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.product_high != '0))
         |-> (rsp_item.c_update && rsp_item.write_back && !rsp_item.flag_v))
      else $error("upper product word on a non-multiply result");

   // negative and zero exclude each other
   a_n_z: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_item.flag_n && rsp_item.flag_z))
      else $error("flag_n and flag_z both set");
`endif

endmodule

// ----- bench/double_operand_alu_tb.sv -----
module double_operand_alu_tb;
   import dalu_pkg::*;

   // codes fourteen and fifteen have no operation behind them
   localparam logic [3:0] OP_SPARE_LO = 4'd14;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;

   // signed range that a product must stay in to leave carry clear
   localparam int PRODUCT_MIN = -32768;
   localparam int PRODUCT_MAX = 32767;

   // cycles from acceptance to the result beat, plus some slack
   localparam int RESULT_LATENCY = 3;
   localparam int DRAIN_LIMIT    = 200;

   // ---------------------------------------------------------------
   // expected-result store with its own model of the execute unit
   // ---------------------------------------------------------------
   class alu_scoreboard;
      req_type pending_inputs[$];
      rsp_type pending_results[$];
      int      mismatches;

      function new();
         mismatches = 0;
      endfunction

      // what the unit must produce for one operand pair
      function rsp_type compute_result(req_type item);
         rsp_type          r;
         logic [15:0]      s, d, w;
         logic [16:0]      sum;
         logic [7:0]       sb, db, bdiff;
         logic signed [31:0] prod;
         logic             byte_form;
         r         = '0;
         s         = item.src_value;
         d         = item.dst_value;
         w         = '0;
         byte_form = 1'b0;
         r.write_back = 1'b1;
         case (item.opcode)
            OP_BIT: begin
               w = s & d;
               r.write_back = 1'b0;
            end
            OP_BITB: begin
               w = s & d;
               r.write_back = 1'b0;
               byte_form = 1'b1;
            end
            OP_BIC:  w = ~s & d;
            OP_BICB: begin
               w = ~s & d;
               byte_form = 1'b1;
            end
            OP_BIS:  w = s | d;
            OP_BISB: begin
               w = s | d;
               byte_form = 1'b1;
            end
            OP_ADD: begin
               sum = {1'b0, s} + {1'b0, d};
               w = sum[15:0];
               r.flag_c   = sum[16];
               r.flag_v   = ~(s[15] ^ d[15]) & (s[15] ^ w[15]);
               r.c_update = 1'b1;
            end
            OP_SUB: begin
               w = d - s;
               r.flag_c   = d < s;
               r.flag_v   = (s[15] ^ d[15]) & ~(s[15] ^ w[15]);
               r.c_update = 1'b1;
            end
            OP_MOV:  w = s;
            OP_MOVB: begin
               w = s;
               byte_form = 1'b1;
            end
            OP_CMP: begin
               w = s - d;
               r.flag_c     = s < d;
               r.flag_v     = (s[15] ^ d[15]) & ~(d[15] ^ w[15]);
               r.c_update   = 1'b1;
               r.write_back = 1'b0;
            end
            OP_CMPB: begin
               sb    = s[7:0];
               db    = d[7:0];
               bdiff = sb - db;
               w     = {8'h00, bdiff};
               r.flag_c     = sb < db;
               r.flag_v     = (sb[7] ^ db[7]) & ~(db[7] ^ bdiff[7]);
               r.c_update   = 1'b1;
               r.write_back = 1'b0;
               byte_form    = 1'b1;
            end
            OP_XOR:  w = s ^ d;
            OP_MUL: begin
               prod = $signed(s) * $signed(d);
               r.result_word  = prod[15:0];
               r.product_high = prod[31:16];
               r.flag_n       = prod < 0;
               r.flag_z       = prod == 0;
               r.flag_c       = (prod < PRODUCT_MIN) || (prod > PRODUCT_MAX);
               r.c_update     = 1'b1;
               return r;
            end
            default: return '0;
         endcase
         if (byte_form) begin
            w[15:8]  = 8'h00;
            r.flag_n = w[7];
         end else begin
            r.flag_n = w[15];
         end
         r.flag_z      = (w == 16'h0000);
         r.result_word = w;
         return r;
      endfunction

      function void note_beat(req_type item);
         pending_inputs.push_back(item);
         pending_results.push_back(compute_result(item));
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      task report(string msg);
         $display("alu check: %s", msg);
         mismatches++;
      endtask

      task field_check(string field, logic [15:0] got, logic [15:0] want, req_type item);
         if (got !== want)
            report($sformatf("op %0d src %h dst %h: %s is %h, want %h",
                             item.opcode, item.src_value, item.dst_value, field, got, want));
      endtask

      task check_beat(rsp_type got);
         req_type item;
         rsp_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result beat %h with nothing outstanding", got));
            return;
         end
         item = pending_inputs.pop_front();
         want = pending_results.pop_front();
         field_check("result_word", got.result_word, want.result_word, item);
         field_check("product_high", got.product_high, want.product_high, item);
         field_check("write_back", 16'(got.write_back), 16'(want.write_back), item);
         field_check("flag_n", 16'(got.flag_n), 16'(want.flag_n), item);
         field_check("flag_z", 16'(got.flag_z), 16'(want.flag_z), item);
         field_check("flag_v", 16'(got.flag_v), 16'(want.flag_v), item);
         field_check("flag_c", 16'(got.flag_c), 16'(want.flag_c), item);
         field_check("c_update", 16'(got.c_update), 16'(want.c_update), item);
      endtask

      task drain_check();
         if (pending_results.size() != 0)
            report($sformatf("%0d results never arrived", pending_results.size()));
      endtask
   endclass

   // ---------------------------------------------------------------
   // clock, reset and the unit under test
   // ---------------------------------------------------------------
   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   alu_scoreboard board = new();

   always #5 clock = ~clock;

   double_operand_alu i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // every result shows for one cycle only, so sample each edge
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         board.check_beat(rsp_item);
   end

   // ---------------------------------------------------------------
   // driving tasks
   // ---------------------------------------------------------------

   // present one beat; start stays high afterwards so back-to-back beats
   // never see a low-then-high pair of assignments in the same step
   task automatic send_beat(input req_type item, input int gap_odds);
      int idle;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         // idle burst before this beat
         idle = $urandom_range(1, 7);
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      // taken at the first edge with start high and busy low
      do @(posedge clock); while (busy !== 1'b0);
      board.note_beat(item);
   endtask

   task automatic send_op(input logic [3:0] op, input logic [15:0] s, input logic [15:0] d);
      req_type item;
      item.opcode    = op;
      item.src_value = s;
      item.dst_value = d;
      send_beat(item, 3);
   endtask

   // operand values leaning toward sign, carry and overflow corners
   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 7))
               0: return 16'h0000;
               1: return 16'h0001;
               2: return 16'h7FFF;
               3: return 16'h8000;
               4: return 16'hFFFF;
               5: return 16'h007F;
               6: return 16'h0080;
               default: return 16'h00FF;
            endcase
         end
         1: return 16'($urandom_range(0, 255));
         2: return 16'hFFFF - 16'($urandom_range(0, 255));
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic run_directed();
      // carry out with a zero sum, then signed overflow
      send_op(OP_ADD, 16'hFFFF, 16'h0001);
      send_op(OP_ADD, 16'h7FFF, 16'h0001);
      // borrow, and overflow going below the negative limit
      send_op(OP_SUB, 16'h0001, 16'h0000);
      send_op(OP_SUB, 16'h0001, 16'h8000);
      // compare runs source minus destination
      send_op(OP_CMP, 16'h8000, 16'h0001);
      send_op(OP_CMP, 16'h1234, 16'h1234);
      send_op(OP_CMPB, 16'hFF80, 16'h0001);
      send_op(OP_CMPB, 16'h0000, 16'h00FF);
      // product corners: most negative squared, -1 squared, zero, just out of range
      send_op(OP_MUL, 16'h8000, 16'h8000);
      send_op(OP_MUL, 16'hFFFF, 16'hFFFF);
      send_op(OP_MUL, 16'h0000, 16'h8000);
      send_op(OP_MUL, 16'h0100, 16'h0080);
      send_op(OP_MUL, 16'hFFFF, 16'h8000);
      send_op(OP_MUL, 16'h0100, 16'hFF80);
      // byte move keeps the high byte zero, no sign extension
      send_op(OP_MOVB, 16'hFF80, 16'hFFFF);
      send_op(OP_MOV, 16'h0000, 16'hFFFF);
      // logical ops leave carry alone
      send_op(OP_BIT, 16'h00FF, 16'hFF00);
      send_op(OP_BITB, 16'hFF80, 16'h0080);
      send_op(OP_BIC, 16'hFFFF, 16'hFFFF);
      send_op(OP_BICB, 16'h0001, 16'h80FF);
      send_op(OP_BIS, 16'h8000, 16'h0000);
      send_op(OP_BISB, 16'h0000, 16'hFF00);
      send_op(OP_XOR, 16'hAAAA, 16'h5555);
      // unassigned codes give an all-zero result
      send_op(OP_SPARE_LO, 16'hFFFF, 16'hFFFF);
      send_op(OP_SPARE_HI, 16'h8000, 16'h7FFF);
   endtask

   task automatic run_random(input int count);
      req_type item;
      int      gap_odds;
      gap_odds = 0;
      for (int i = 0; i < count; i++) begin
         // idling pattern changes every so often, and stops near the end
         if (i % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: gap_odds = 0;
               1: gap_odds = 2;
               2: gap_odds = 4;
               default: gap_odds = 8;
            endcase
         end
         if (i >= count - 200)
            gap_odds = 0;
         item.opcode    = 4'($urandom_range(0, 15));
         item.src_value = pick_operand();
         item.dst_value = pick_operand();
         send_beat(item, gap_odds);
      end
   endtask

   // ---------------------------------------------------------------
   // run sequence
   // ---------------------------------------------------------------
   initial begin
      int waited;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(1550);
      start <= 1'b0;

      // let the last beats come out of the pipeline
      waited = 0;
      while (board.outstanding() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (RESULT_LATENCY + 5) @(posedge clock);
      board.drain_check();

      if (board.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
